// ===== sv/ctt_pkg.sv =====
package ctt_pkg;

    // Runs given out by one dispatch at most
    localparam int MAX_RUNS = 8;
    localparam int RUN_W = $clog2(MAX_RUNS + 1);

    // Queue depths
    localparam int CMD_DEPTH = 2;
    localparam int OUT_DEPTH = 2 * MAX_RUNS;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_ADD      = 2'd1,
        ACT_DELETE   = 2'd2,
        ACT_DISPATCH = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] task_id;
        logic [7:0]  first_delay;
        logic [7:0]  repeat_period;
        logic [2:0]  slot;
    } in_item_t;

    typedef struct packed {
        logic [15:0] ran_task_id;
        logic [2:0]  ran_slot;
        logic        has_run;
        logic [2:0]  added_slot;
        logic        add_ok;
        logic        deleted_existing;
        logic        full_seen;
        logic        last_of_run;
    } out_item_t;

    // Decoded command passed from front to back
    typedef struct packed {
        action_t     op;
        logic [15:0] task_id;
        logic [7:0]  first_delay;
        logic [7:0]  repeat_period;
        logic [2:0]  slot;
        logic        slot_in_range;
        logic        null_task;
    } cmd_t;

    // One slot of the task table
    typedef struct packed {
        logic [15:0] task_id;
        logic [7:0]  delay;
        logic [7:0]  period;
        logic [7:0]  pending;
    } entry_t;

endpackage

// ===== sv/ctt_fifo.sv =====
module ctt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push_valid,
    output logic                       push_ready,
    input  logic [WIDTH-1:0]           push_data,
    output logic                       pop_valid,
    input  logic                       pop_ready,
    output logic [WIDTH-1:0]           pop_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = data_mem[rd_ptr_reg];
    assign count      = count_reg;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the item at the write pointer
    always_ff @(posedge aclk) begin
        if (do_push) begin
            data_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/ctt_front.sv =====
module ctt_front #(
    parameter int SLOT_COUNT = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ctt_pkg::in_item_t s_item,
    output logic            cmd_valid,
    input  logic            cmd_ready,
    output ctt_pkg::cmd_t   cmd
);

    logic          cmd_valid_reg, cmd_valid_next;
    ctt_pkg::cmd_t cmd_reg, cmd_next;

    assign s_ready   = !cmd_valid_reg || cmd_ready;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    // Classify the incoming item
    always_comb begin
        cmd_next.op            = ctt_pkg::action_t'(s_item.action);
        cmd_next.task_id       = s_item.task_id;
        cmd_next.first_delay   = s_item.first_delay;
        cmd_next.repeat_period = s_item.repeat_period;
        cmd_next.slot          = s_item.slot;
        cmd_next.slot_in_range = (32'(s_item.slot) < 32'(SLOT_COUNT));
        cmd_next.null_task     = (s_item.task_id == 16'd0);
    end

    // Hold one decoded item until the queue takes it
    always_comb begin
        cmd_valid_next = cmd_valid_reg;
        if (s_valid && s_ready) begin
            cmd_valid_next = 1'b1;
        end else if (cmd_ready) begin
            cmd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// ===== sv/ctt_back.sv =====
module ctt_back #(
    parameter int SLOT_COUNT = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  ctt_pkg::cmd_t                   cmd,
    output logic                            res_valid,
    output ctt_pkg::out_item_t              res,
    input  logic [ctt_pkg::OUT_CNT_W-1:0]   out_count
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int RUN_W = ctt_pkg::RUN_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t                  state_reg, state_next;
    ctt_pkg::action_t        op_reg, op_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [RUN_W-1:0]        runs_reg, runs_next;
    logic                    held_valid_reg, held_valid_next;
    logic [15:0]             held_task_reg, held_task_next;
    logic [IDX_W-1:0]        held_slot_reg, held_slot_next;
    logic                    full_reg, full_next;
    logic [SLOT_COUNT-1:0]   occ_reg, occ_next;

    // Slot table memory
    ctt_pkg::entry_t         slot_mem [SLOT_COUNT];
    ctt_pkg::entry_t         rd_data_reg;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_wa;
    logic [IDX_W-1:0]        mem_ra;
    ctt_pkg::entry_t         mem_wd;

    logic                    free_ok;
    logic                    any_free;
    logic [IDX_W-1:0]        free_idx;
    logic [IDX_W-1:0]        del_idx;
    logic                    last_slot;
    ctt_pkg::entry_t         cur;

    assign free_ok   = (out_count <= ctt_pkg::OUT_CNT_W'(ctt_pkg::OUT_DEPTH - ctt_pkg::MAX_RUNS));
    assign del_idx   = IDX_W'({{IDX_W{1'b0}}, cmd.slot});
    assign last_slot = (idx_reg == IDX_W'(SLOT_COUNT - 1));
    assign cur       = rd_data_reg;

    // Find the lowest empty slot
    always_comb begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!occ_reg[i]) begin
                any_free = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // Sequence the commands
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        runs_next       = runs_reg;
        held_valid_next = held_valid_reg;
        held_task_next  = held_task_reg;
        held_slot_next  = held_slot_reg;
        full_next       = full_reg;
        occ_next        = occ_reg;
        mem_we          = 1'b0;
        mem_wa          = idx_reg;
        mem_wd          = cur;
        mem_ra          = idx_reg;
        cmd_ready       = 1'b0;
        res_valid       = 1'b0;
        res             = '0;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && free_ok) begin
                    case (cmd.op)
                        ctt_pkg::ACT_ADD: begin
                            cmd_ready = 1'b1;
                            res_valid = 1'b1;
                            if (!cmd.null_task) begin
                                if (any_free) begin
                                    mem_we             = 1'b1;
                                    mem_wa             = free_idx;
                                    mem_wd.task_id     = cmd.task_id;
                                    mem_wd.delay       = cmd.first_delay;
                                    mem_wd.period      = cmd.repeat_period;
                                    mem_wd.pending     = 8'd0;
                                    occ_next[free_idx] = 1'b1;
                                    res.added_slot     = 3'({3'b000, free_idx});
                                    res.add_ok         = 1'b1;
                                end else begin
                                    full_next = 1'b1;
                                end
                            end
                            res.full_seen   = full_next;
                            res.last_of_run = 1'b1;
                        end
                        ctt_pkg::ACT_DELETE: begin
                            cmd_ready = 1'b1;
                            res_valid = 1'b1;
                            if (cmd.slot_in_range) begin
                                res.deleted_existing = occ_reg[del_idx];
                                occ_next[del_idx]    = 1'b0;
                            end
                            res.full_seen   = full_reg;
                            res.last_of_run = 1'b1;
                        end
                        default: begin
                            // Tick or dispatch: start a scan at slot zero
                            op_next         = cmd.op;
                            mem_ra          = '0;
                            idx_next        = '0;
                            runs_next       = '0;
                            held_valid_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // Data for idx_reg is in rd_data_reg; read the next slot
                mem_ra   = idx_reg + 1'b1;
                idx_next = idx_reg + 1'b1;
                if (last_slot) begin
                    state_next = ST_FLUSH;
                end
                if (op_reg == ctt_pkg::ACT_TICK) begin
                    if (occ_reg[idx_reg]) begin
                        mem_we = 1'b1;
                        if (cur.delay == 8'd0) begin
                            if (cur.pending != 8'hFF) begin
                                mem_wd.pending = cur.pending + 8'd1;
                            end
                            if (cur.period != 8'd0) begin
                                mem_wd.delay = cur.period;
                            end
                        end else begin
                            mem_wd.delay = cur.delay - 8'd1;
                        end
                    end
                end else if (occ_reg[idx_reg] && cur.pending != 8'd0) begin
                    // Dispatch one run; hand the previous one on
                    mem_we         = 1'b1;
                    mem_wd.pending = cur.pending - 8'd1;
                    if (cur.period == 8'd0) begin
                        occ_next[idx_reg] = 1'b0;
                    end
                    if (held_valid_reg) begin
                        res_valid       = 1'b1;
                        res.ran_task_id = held_task_reg;
                        res.ran_slot    = 3'({3'b000, held_slot_reg});
                        res.has_run     = 1'b1;
                        res.full_seen   = full_reg;
                    end
                    held_valid_next = 1'b1;
                    held_task_next  = cur.task_id;
                    held_slot_next  = idx_reg;
                    runs_next       = runs_reg + 1'b1;
                    if (runs_reg == RUN_W'(ctt_pkg::MAX_RUNS - 1)) begin
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_FLUSH: begin
                // Emit the final result of the scan
                cmd_ready       = 1'b1;
                res_valid       = 1'b1;
                res.ran_task_id = held_valid_reg ? held_task_reg : 16'd0;
                res.ran_slot    = held_valid_reg ? 3'({3'b000, held_slot_reg}) : 3'd0;
                res.has_run     = held_valid_reg;
                res.full_seen   = full_reg;
                res.last_of_run = 1'b1;
                held_valid_next = 1'b0;
                state_next      = ST_IDLE;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            op_reg         <= ctt_pkg::ACT_TICK;
            idx_reg        <= '0;
            runs_reg       <= '0;
            held_valid_reg <= 1'b0;
            full_reg       <= 1'b0;
            occ_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            idx_reg        <= idx_next;
            runs_reg       <= runs_next;
            held_valid_reg <= held_valid_next;
            full_reg       <= full_next;
            occ_reg        <= occ_next;
        end
    end

    // Held run payload
    always_ff @(posedge aclk) begin
        held_task_reg <= held_task_next;
        held_slot_reg <= held_slot_next;
    end

    // Single write port, single registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= slot_mem[mem_ra];
    end

endmodule

// ===== sv/cooperative_task_timer_table.sv =====
// Channel   Ports                       Payload                 Direction
// input     s_valid, s_ready, s_item    ctt_pkg::in_item_t      in
// result    m_valid, m_ready, m_item    ctt_pkg::out_item_t     out
//
// Add and delete complete in the executor's idle state; tick and dispatch scan the
// slot memory one slot per cycle, then emit a final result from the flush state.
// A dispatch stops its scan after its eighth run.
// Synchronous active-low reset empties every slot at once through per-slot occupancy
// bits and clears the full flag and both queues; no clearing pass follows.
// The executor starts an item only with at least eight free places in the 16-deep
// result queue, so a stalled m_ready stalls it between items, never inside one.
module cooperative_task_timer_table #(
    parameter int SLOT_COUNT = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ctt_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output ctt_pkg::out_item_t m_item
);

    localparam int CMD_W = $bits(ctt_pkg::cmd_t);
    localparam int RES_W = $bits(ctt_pkg::out_item_t);

    logic                          fr_valid, fr_ready;
    ctt_pkg::cmd_t                 fr_cmd;
    logic                          q_valid, q_ready;
    ctt_pkg::cmd_t                 q_cmd;
    logic                          res_valid;
    ctt_pkg::out_item_t            res;
    logic [ctt_pkg::OUT_CNT_W-1:0] out_count;
    logic [$clog2(ctt_pkg::CMD_DEPTH+1)-1:0] cmd_count;

    // Accept and decode items
    ctt_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .cmd_valid (fr_valid),
        .cmd_ready (fr_ready),
        .cmd       (fr_cmd)
    );

    // Command queue between front and executor
    ctt_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (ctt_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_data  (fr_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_cmd),
        .count      (cmd_count)
    );

    // Execute commands against the slot table
    ctt_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .res_valid (res_valid),
        .res       (res),
        .out_count (out_count)
    );

    // Result queue toward the consumer
    ctt_fifo #(
        .WIDTH (RES_W),
        .DEPTH (ctt_pkg::OUT_DEPTH)
    ) u_out_q (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (res_valid),
        .push_ready (),
        .push_data  (res),
        .pop_valid  (m_valid),
        .pop_ready  (m_ready),
        .pop_data   (m_item),
        .count      (out_count)
    );

endmodule
